// ===== rtl/core/shs_pkg.sv =====
// shared types and constants for the streaming sha-256 hasher
// no dependencies; imported by shs_compress and sha256_stream_hasher
`default_nettype none

package shs_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BUF_WORDS = 16;
    localparam int unsigned BUF_AW   = 4;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned ROUND_W  = 6;
    localparam int unsigned FILL_W   = 6;
    localparam int unsigned BITS_W   = 64;
    localparam int unsigned DIGEST_WORDS = 8;
    localparam int unsigned IDX_W    = 3;

    localparam logic [FILL_W-1:0] FILL_LEN_LIMIT = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST      = 6'd63;
    localparam logic [7:0]        PAD_MARK       = 8'h80;
    localparam logic [IDX_W-1:0]  IDX_LAST       = 3'd7;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t chain_t [DIGEST_WORDS];

    localparam chain_t INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROUNDS,
        ST_EMIT
    } shs_state_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD_MSG,
        BLK_PAD_LEN
    } blk_kind_t;

    typedef struct packed {
        logic running;
        logic done;
    } comp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/shs_msg_if.sv =====
// message byte channel of the hasher
// depends on nothing
`default_nettype none

interface shs_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/shs_digest_if.sv =====
// digest word channel of the hasher
// depends on nothing
`default_nettype none

interface shs_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/shs_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module shs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/shs_compress.sv =====
// sha-256 compression: one round per cycle on a shared round unit,
// with a sixteen-word window for the message schedule; uses shs_pkg
`default_nettype none

module shs_compress (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire shs_pkg::chain_t        chain_in,
    input  wire shs_pkg::word_t         msg_word,
    output logic [shs_pkg::ROUND_W-1:0] round,
    output shs_pkg::chain_t             work,
    output shs_pkg::comp_sts_t          sts
);
    import shs_pkg::*;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} >> n;
        return dbl[WORD_W-1:0];
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    chain_t              v_reg, v_next;
    word_t               win_reg [BUF_WORDS];
    word_t               win_next [BUF_WORDS];
    logic [ROUND_W-1:0]  t_reg, t_next;
    logic                running_reg, running_next;
    logic                done_reg, done_next;

    word_t w_sched, w_t, t1, t2, ch, maj;

    always_comb
    begin
        w_sched = small_sigma1(win_reg[14]) + win_reg[9]
                + small_sigma0(win_reg[1]) + win_reg[0];
        w_t = (t_reg < ROUND_W'(BUF_WORDS)) ? msg_word : w_sched;
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[t_reg] + w_t;
        t2  = big_sigma0(v_reg[0]) + maj;
    end

    always_comb
    begin
        v_next       = v_reg;
        win_next     = win_reg;
        t_next       = t_reg;
        running_next = running_reg;
        done_next    = 1'b0;
        if (start)
        begin
            v_next       = chain_in;
            t_next       = '0;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            for (int i = 0; i < BUF_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[BUF_WORDS-1] = w_t;
            t_next = t_reg + 1'b1;
            if (t_reg == ROUND_W'(ROUNDS - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg       <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            t_reg       <= t_next;
            running_reg <= running_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        win_reg <= win_next;
    end

    assign round       = t_reg;
    assign work        = v_reg;
    assign sts.running = running_reg;
    assign sts.done    = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
// streaming sha-256 hasher top level: byte intake, padding, block sequencer
// uses shs_pkg, shs_msg_if, shs_digest_if, shs_ram and shs_compress
//
// msg carries one transaction per item: data_byte counts only when
// byte_present is high, end_of_message closes the message. digest returns
// the eight digest words, word_index 0 first, last_word on word 7.
// an item that neither fills a block nor ends the message leaves msg.ready
// high for the next item. the item that completes a 64-byte block holds
// msg.ready low through a read set-up state, 64 rounds of the single
// shared round unit and one chaining add. an ending item adds one
// padded block, or two when 56 or more bytes are pending, and then
// offers the eight digest words, one per cycle while digest.ready is high.
// a stall on digest holds the current word and no new message is taken
// until word 7 has gone; the chaining words then return to the initial
// hash values and the byte and bit counts clear.
// reset brings back the initial hash values with empty counts; the block
// buffer needs no clearing as padding never reads a word it did not write.
`default_nettype none

module sha256_stream_hasher (
    input  wire logic    clk,
    input  wire logic    rst_n,
    shs_msg_if.sink      msg,
    shs_digest_if.source digest
);
    import shs_pkg::*;

    shs_state_t           state_reg, state_next;
    blk_kind_t            kind_reg, kind_next;
    logic                 eom_reg, eom_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [BITS_W-1:0]    bits_reg, bits_next;
    word_t                asm_reg, asm_next;
    chain_t               chain_reg, chain_next;
    logic [IDX_W-1:0]     emit_idx_reg, emit_idx_next;

    word_t                asm_wr, partial, msg_word, ram_rdata;
    logic                 ram_we;
    logic [BUF_AW-1:0]    ram_raddr, word_sel, fill_word;
    logic                 comp_start;
    logic [ROUND_W-1:0]   round;
    chain_t               work;
    comp_sts_t            comp_sts;

    shs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUF_WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[FILL_W-1:2]),
        .wdata (asm_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    shs_compress u_comp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (comp_start),
        .chain_in (chain_reg),
        .msg_word (msg_word),
        .round    (round),
        .work     (work),
        .sts      (comp_sts)
    );

    // byte lanes are big-endian inside a word
    always_comb
    begin
        asm_wr = asm_reg;
        unique case (fill_reg[1:0])
            2'd0: asm_wr[31:24] = msg.data_byte;
            2'd1: asm_wr[23:16] = msg.data_byte;
            2'd2: asm_wr[15:8]  = msg.data_byte;
            2'd3: asm_wr[7:0]   = msg.data_byte;
        endcase
    end

    always_comb
    begin
        unique case (fill_reg[1:0])
            2'd0: partial = {PAD_MARK, 24'h0};
            2'd1: partial = {asm_reg[31:24], PAD_MARK, 16'h0};
            2'd2: partial = {asm_reg[31:16], PAD_MARK, 8'h0};
            2'd3: partial = {asm_reg[31:8], PAD_MARK};
        endcase
    end

    // message word for the first sixteen rounds, padding built on the fly
    always_comb
    begin
        word_sel  = round[BUF_AW-1:0];
        fill_word = fill_reg[FILL_W-1:2];
        msg_word  = '0;
        unique case (kind_reg)
            BLK_DATA:
            begin
                msg_word = ram_rdata;
            end
            BLK_PAD_MSG:
            begin
                if (word_sel < fill_word)
                begin
                    msg_word = ram_rdata;
                end
                else if (word_sel == fill_word)
                begin
                    msg_word = partial;
                end
                else if (fill_reg < FILL_LEN_LIMIT && word_sel == BUF_AW'(14))
                begin
                    msg_word = bits_reg[63:32];
                end
                else if (fill_reg < FILL_LEN_LIMIT && word_sel == BUF_AW'(15))
                begin
                    msg_word = bits_reg[31:0];
                end
            end
            BLK_PAD_LEN:
            begin
                if (word_sel == BUF_AW'(14))
                begin
                    msg_word = bits_reg[63:32];
                end
                else if (word_sel == BUF_AW'(15))
                begin
                    msg_word = bits_reg[31:0];
                end
            end
            default:
            begin
                msg_word = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        eom_next      = eom_reg;
        fill_next     = fill_reg;
        bits_next     = bits_reg;
        asm_next      = asm_reg;
        chain_next    = chain_reg;
        emit_idx_next = emit_idx_reg;
        ram_we        = 1'b0;
        ram_raddr     = round[BUF_AW-1:0] + 1'b1;
        comp_start    = 1'b0;
        msg.ready     = 1'b0;
        digest.valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    if (msg.byte_present)
                    begin
                        asm_next  = asm_wr;
                        ram_we    = (fill_reg[1:0] == 2'd3);
                        fill_next = fill_reg + 1'b1;
                        bits_next = bits_reg + BITS_W'(8);
                    end
                    if (msg.byte_present && fill_reg == FILL_LAST)
                    begin
                        kind_next  = BLK_DATA;
                        eom_next   = msg.end_of_message;
                        state_next = ST_PREP;
                    end
                    else if (msg.end_of_message)
                    begin
                        kind_next  = BLK_PAD_MSG;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                ram_raddr  = '0;
                comp_start = 1'b1;
                state_next = ST_ROUNDS;
            end
            ST_ROUNDS:
            begin
                if (comp_sts.done)
                begin
                    for (int i = 0; i < DIGEST_WORDS; i++)
                    begin
                        chain_next[i] = chain_reg[i] + work[i];
                    end
                    priority if (kind_reg == BLK_DATA && eom_reg)
                    begin
                        kind_next  = BLK_PAD_MSG;
                        state_next = ST_PREP;
                    end
                    else if (kind_reg == BLK_DATA)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (kind_reg == BLK_PAD_MSG && fill_reg >= FILL_LEN_LIMIT)
                    begin
                        kind_next  = BLK_PAD_LEN;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        emit_idx_next = '0;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                digest.valid = 1'b1;
                if (digest.ready)
                begin
                    emit_idx_next = emit_idx_reg + 1'b1;
                    if (emit_idx_reg == IDX_LAST)
                    begin
                        chain_next = INIT_HASH;
                        fill_next  = '0;
                        bits_next  = '0;
                        eom_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kind_reg     <= BLK_DATA;
            eom_reg      <= 1'b0;
            fill_reg     <= '0;
            bits_reg     <= '0;
            chain_reg    <= INIT_HASH;
            emit_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            eom_reg      <= eom_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            chain_reg    <= chain_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
    end

    assign digest.digest_word = chain_reg[emit_idx_reg];
    assign digest.word_index  = emit_idx_reg;
    assign digest.last_word   = (emit_idx_reg == IDX_LAST);

endmodule

`default_nettype wire

// ===== tb/tb_sha256_stream_hasher.sv =====
// self-checking testbench for sha256_stream_hasher: byte messages in, digest words out
// depends on rtl/core/shs_msg_if.sv, rtl/core/shs_digest_if.sv and the hasher rtl
// a scoreboard class predicts every digest word and checks each digest transaction
`default_nettype none

module tb_sha256_stream_hasher;

    localparam int ITEM_TARGET  = 470;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 200;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [2:0] FINAL_IDX  = 3'd7;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
    } digest_word_t;

    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [7:0]   blk [64];
        logic [5:0]   fill;
        logic [63:0]  bit_count;
        digest_word_t expected_words [$];
        int           mismatches;

        function new();
            restart_message();
            mismatches = 0;
        endfunction

        function void restart_message();
            chain = SHA_IV;
            fill = '0;
            bit_count = '0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0;
            logic [31:0] s1;
            logic [31:0] t1;
            logic [31:0] t2;
            for (int r = 0; r < 16; r++)
            begin
                w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
            end
            for (int r = 16; r < 64; r++)
            begin
                s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = s1 + w[r-7] + s0 + w[r-16];
            end
            v = chain;
            for (int r = 0; r < 64; r++)
            begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                for (int j = 7; j > 0; j--)
                begin
                    v[j] = v[j-1];
                end
                v[4] = v[4] + t1;
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++)
            begin
                chain[j] = chain[j] + v[j];
            end
        endfunction

        // one accepted message transaction
        function void note_item(logic [7:0] data_byte, logic present, logic ending);
            digest_word_t dw;
            if (present)
            begin
                blk[fill] = data_byte;
                fill = fill + 6'd1;
                bit_count = bit_count + 64'd8;
                if (fill == '0)
                    compress_block();
            end
            if (!ending)
                return;
            blk[fill] = PAD_BYTE;
            for (int i = int'(fill) + 1; i < 64; i++)
            begin
                blk[i] = '0;
            end
            // no room left for the length field
            if (fill >= LEN_START)
            begin
                compress_block();
                foreach (blk[i])
                    blk[i] = '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                blk[63-i] = bit_count[8*i +: 8];
            end
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                dw.word = chain[i];
                dw.idx = 3'(i);
                dw.is_last = (3'(i) == FINAL_IDX);
                expected_words.push_back(dw);
            end
            restart_message();
        endfunction

        function void check_digest_word(logic [31:0] word, logic [2:0] idx, logic is_last);
            digest_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("unexpected digest transaction: digest_word %h word_index %0d", word, idx);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (word !== want.word)
            begin
                $error("digest_word expected %h actual %h", want.word, word);
                mismatches++;
            end
            if (idx !== want.idx)
            begin
                $error("word_index expected %0d actual %0d", want.idx, idx);
                mismatches++;
            end
            if (is_last !== want.is_last)
            begin
                $error("last_word expected %0b actual %0b", want.is_last, is_last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    shs_msg_if    msg_ch ();
    shs_digest_if dig_ch ();

    sha256_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    digest_scoreboard hasher_sb = new();

    logic [7:0] msg_bytes [$];
    int         items_sent;
    bit         sender_calm;
    bit         hold_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic sender_gap();
        int gap;
        int pick;
        gap = 0;
        pick = $urandom_range(0, 99);
        if (!sender_calm)
        begin
            if (pick >= 95)
                gap = $urandom_range(10, 40);
            else if (pick >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic [7:0] data_byte, input logic present,
                             input logic ending);
        msg_ch.valid          <= 1'b1;
        msg_ch.data_byte      <= data_byte;
        msg_ch.byte_present   <= present;
        msg_ch.end_of_message <= ending;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        hasher_sb.note_item(data_byte, present, ending);
        if (present || ending)
            items_sent++;
        sender_gap();
    endtask

    // sends msg_bytes, with an extra ending transaction unless the last byte closes it
    task automatic send_message(input bit end_with_byte, input bit bubbles);
        int n;
        n = msg_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if (bubbles && $urandom_range(0, 7) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(msg_bytes[i], 1'b1, end_with_byte && (i == n - 1));
        end
        if (!end_with_byte || n == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic fill_random(input int n);
        msg_bytes.delete();
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        while (hasher_sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin : digest_sink
        int  stall_left;
        int  hold_left;
        int  phase_cnt;
        int  pick;
        bit  calm;
        bit  held;
        logic nxt;
        stall_left = 0;
        hold_left = 0;
        phase_cnt = 0;
        calm = 1'b0;
        held = 1'b0;
        dig_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (dig_ch.valid && dig_ch.ready)
                hasher_sb.check_digest_word(dig_ch.digest_word, dig_ch.word_index,
                                            dig_ch.last_word);
            nxt = 1'b1;
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else if (hold_req && !held)
            begin
                hold_left = HOLD_CYCLES;
                held = 1'b1;
                nxt = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt = 1'b0;
            end
            else
            begin
                phase_cnt++;
                if (phase_cnt % 256 == 0)
                    calm = ($urandom_range(0, 2) == 0);
                if (!calm)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick >= 97)
                    begin
                        stall_left = $urandom_range(15, 50);
                        nxt = 1'b0;
                    end
                    else if (pick >= 80)
                    begin
                        stall_left = $urandom_range(0, 2);
                        nxt = 1'b0;
                    end
                end
            end
            dig_ch.ready <= nxt;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int  msg_no;
        int  len;
        int  pick;
        bit  end_with_byte;
        items_sent = 0;
        sender_calm = 1'b1;
        hold_req = 1'b0;
        rst_n                 <= 1'b0;
        msg_ch.valid          <= 1'b0;
        msg_ch.data_byte      <= '0;
        msg_ch.byte_present   <= 1'b0;
        msg_ch.end_of_message <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message
        msg_bytes.delete();
        send_message(1'b1, 1'b0);
        msg_bytes = '{8'h61, 8'h62, 8'h63};
        send_message(1'b1, 1'b0);
        msg_bytes = '{8'h00};
        send_message(1'b1, 1'b0);
        // ignored transaction inside a message, ending without a byte
        send_item(8'h5a, 1'b0, 1'b0);
        msg_bytes = '{8'hff, 8'h80};
        send_message(1'b0, 1'b0);
        msg_bytes.delete();
        send_message(1'b0, 1'b0);

        msg_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            end_with_byte = ($urandom_range(0, 1) == 1);
            case (msg_no)
                0:
                begin
                    len = 55;
                    end_with_byte = 1'b1;
                end
                1:
                begin
                    len = 56;
                    end_with_byte = 1'b0;
                end
                2:
                begin
                    len = 64;
                    end_with_byte = 1'b1;
                end
                default:
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        len = $urandom_range(0, 12);
                    else if (pick < 85)
                        len = $urandom_range(13, 40);
                    else
                        len = $urandom_range(41, 70);
                end
            endcase
            if (msg_no == 3)
                hold_req = 1'b1;
            if (msg_no == 6)
                wait_drained();
            sender_calm = ($urandom_range(0, 3) == 0);
            fill_random(len);
            send_message(end_with_byte, $urandom_range(0, 2) == 0);
            msg_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (hasher_sb.mismatches == 0 && hasher_sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/shs_pkg.sv
rtl/core/shs_msg_if.sv
rtl/core/shs_digest_if.sv
rtl/core/shs_ram.sv
rtl/core/shs_compress.sv
rtl/core/sha256_stream_hasher.sv
tb/tb_sha256_stream_hasher.sv
